@@ rtl/ilre_pkg.sv @@
// Shared types, constants and register codes of the icon line run expander.
package ilre_pkg;

    localparam int ROW_BITS_DEF = 16;
    localparam int SLOTS        = 3;

    localparam logic [15:0] TOP_3D_COLOR = 16'hFFFF;
    localparam logic [15:0] BOT_3D_COLOR = 16'h0000;

    typedef enum logic [2:0] {
        CFG_SCALE         = 3'd0,
        CFG_LINE_WIDTH    = 3'd1,
        CFG_BORDER_ENABLE = 3'd2,
        CFG_BORDER_3D     = 3'd3,
        CFG_FG_COLOR      = 3'd4,
        CFG_BG_COLOR      = 3'd5,
        CFG_BORDER_COLOR  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] above_row;
        logic [15:0] this_row;
        logic [15:0] below_row;
    } t_item;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic [7:0]  run_length;
        logic        last_run;
    } t_result;

    typedef struct packed {
        logic        v;
        logic [15:0] color;
        logic [7:0]  len;
    } t_run;

    typedef t_run [SLOTS-1:0] t_slots;

    typedef struct packed {
        logic        border_enable;
        logic [3:0]  scale;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [15:0] top;
        logic [15:0] bot;
    } t_shade_cfg;

    localparam t_run RUN_NONE = '{v: 1'b0, color: 16'h0000, len: 8'h00};

endpackage

@@ rtl/ilre_bit_decode.sv @@
// Turns one bitmap bit and its neighbours into up to three packed colour runs.
module ilre_bit_decode
    import ilre_pkg::*;
(
    input  logic       i_set,
    input  logic       i_prev,
    input  logic       i_next,
    input  logic       i_above,
    input  logic       i_below,
    input  t_shade_cfg i_cfg,
    output t_slots     o_slots
);

    t_run       r0, r1, r2;
    logic [7:0] s8, s8m1, s8m2;

    function automatic t_run mk(input logic [15:0] color, input logic [7:0] len);
        t_run r;
        r.v     = (len != 8'd0);
        r.color = color;
        r.len   = len;
        return r;
    endfunction

    always_comb begin
        s8   = {4'b0000, i_cfg.scale};
        s8m1 = s8 - 8'd1;
        s8m2 = s8 - 8'd2;
        r0   = RUN_NONE;
        r1   = RUN_NONE;
        r2   = RUN_NONE;
        if (!i_set) begin
            r0 = mk(i_cfg.bg, s8);
        end else if (!i_cfg.border_enable) begin
            r0 = mk(i_cfg.fg, s8);
        end else if (!i_above) begin
            r0 = mk(i_cfg.top, s8);
        end else if (!i_below) begin
            r0 = mk(i_cfg.bot, s8);
        end else if (i_cfg.scale != 4'd0) begin
            if (i_prev && i_next) begin
                r0 = mk(i_cfg.fg, s8);
            end else if (i_prev) begin
                r0 = mk(i_cfg.fg, s8m1);
                r1 = mk(i_cfg.bot, 8'd1);
            end else if (i_next) begin
                r0 = mk(i_cfg.top, 8'd1);
                r1 = mk(i_cfg.fg, s8m1);
            end else begin
                r0 = mk(i_cfg.top, 8'd1);
                if (i_cfg.scale > 4'd1) begin
                    r1 = mk(i_cfg.fg, s8m2);
                    r2 = mk(i_cfg.bot, 8'd1);
                end
            end
        end
    end

    // Empty runs are squeezed out so that slot 0 always holds the next run.
    always_comb begin
        o_slots[0] = r0.v ? r0 : (r1.v ? r1 : r2);
        if (r0.v) begin
            o_slots[1] = r1.v ? r1 : r2;
        end else if (r1.v) begin
            o_slots[1] = r2;
        end else begin
            o_slots[1] = RUN_NONE;
        end
        o_slots[2] = (r0.v && r1.v) ? r2 : RUN_NONE;
    end

endmodule

@@ rtl/ilre_cell.sv @@
// One cell of the run chain: holds a few runs and hands them towards the head.
module ilre_cell
    import ilre_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_slots i_load_slots,
    input  logic   i_shift,
    input  t_slots i_next_slots,
    input  logic   i_pop,
    output t_slots o_slots
);

    t_slots r_slots, n_slots;

    always_comb begin
        n_slots = r_slots;
        if (i_load) begin
            n_slots = i_load_slots;
        end else if (i_shift) begin
            n_slots = i_next_slots;
        end else if (i_pop) begin
            for (int k = 0; k < SLOTS - 1; k++) begin
                n_slots[k] = r_slots[k+1];
            end
            n_slots[SLOTS-1] = RUN_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_slots[k].v <= 1'b0;
            end
        end else begin
            r_slots <= n_slots;
        end
    end

    assign o_slots = r_slots;

endmodule

@@ rtl/icon_line_run_expander_unit.sv @@
// Top level of the icon line run expander: staging, configuration and run chain.
// Path: a transaction waits in the staging register until the chain is free, is loaded
// into the chain cells, and its runs leave through the output registers. Throughput: one
// run per cycle while the head cell holds one; each empty cell reaching the head leaves a
// gap; the receiver cannot stall. While a line holds the chain until its last run leaves,
// the next line can be taken into a one-deep staging register. Reset is synchronous.
module icon_line_run_expander_unit
    import ilre_pkg::*;
#(
    parameter int ROW_BITS = ROW_BITS_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_strobe,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // The chain has a left pad cell, one cell per bitmap bit, and a right pad cell.
    localparam int NC = ROW_BITS + 2;
    localparam int IW = $clog2(ROW_BITS * 15 + 256);

    // Configuration registers.
    logic [3:0]  r_scale;
    logic [7:0]  r_line_width;
    logic        r_border_enable;
    logic        r_border_3d;
    logic [15:0] r_fg_color;
    logic [15:0] r_bg_color;
    logic [15:0] r_border_color;

    // Staging register: holds one accepted transaction until the chain is free.
    logic        r_stage_v;
    t_item       r_stage;

    logic        r_strobe;
    t_result     r_result;

    t_shade_cfg  shade;
    t_slots      cell_q   [NC];
    t_slots      cell_ld  [NC];
    t_slots      cell_nx  [NC];
    logic [NC-1:1] cell_busy;
    t_slots      pad_l, pad_r;

    logic [IW-1:0] icon_w, lw_ext, slack, left_w, right_w;
    logic        any_rest, head_done, load, emit, accept;

    assign o_cfg_ready = 1'b1;
    assign busy        = r_stage_v;
    assign accept      = start && !r_stage_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale         <= 4'd1;
            r_line_width    <= 8'd16;
            r_border_enable <= 1'b0;
            r_border_3d     <= 1'b0;
            r_fg_color      <= 16'hFFFF;
            r_bg_color      <= 16'h0000;
            r_border_color  <= 16'h0000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCALE:         r_scale         <= i_cfg_data[3:0];
                CFG_LINE_WIDTH:    r_line_width    <= i_cfg_data[7:0];
                CFG_BORDER_ENABLE: r_border_enable <= i_cfg_data[0];
                CFG_BORDER_3D:     r_border_3d     <= i_cfg_data[0];
                CFG_FG_COLOR:      r_fg_color      <= i_cfg_data;
                CFG_BG_COLOR:      r_bg_color      <= i_cfg_data;
                CFG_BORDER_COLOR:  r_border_color  <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // The 3D option swaps the single border colour for white above and black below.
    always_comb begin
        shade.border_enable = r_border_enable;
        shade.scale         = r_scale;
        shade.fg            = r_fg_color;
        shade.bg            = r_bg_color;
        shade.top           = r_border_3d ? TOP_3D_COLOR : r_border_color;
        shade.bot           = r_border_3d ? BOT_3D_COLOR : r_border_color;
    end

    // Centring: the left pad takes the lower half of the slack, the right pad the
    // rest. When the icon does not fit, both pads collapse to nothing.
    always_comb begin
        icon_w = IW'(ROW_BITS) * IW'(r_scale);
        lw_ext = IW'(r_line_width);
        if (lw_ext > icon_w) begin
            slack = lw_ext - icon_w;
        end else begin
            slack = '0;
        end
        left_w  = slack >> 1;
        right_w = slack - left_w;
    end

    always_comb begin
        pad_l          = {SLOTS{RUN_NONE}};
        pad_l[0].v     = (left_w != '0);
        pad_l[0].color = r_bg_color;
        pad_l[0].len   = left_w[7:0];
        pad_r          = {SLOTS{RUN_NONE}};
        pad_r[0].v     = (right_w != '0);
        pad_r[0].color = r_bg_color;
        pad_r[0].len   = right_w[7:0];
    end

    assign cell_ld[0]    = pad_l;
    assign cell_ld[NC-1] = pad_r;

    // Bit cells run from the leftmost bitmap bit to the rightmost one.
    for (genvar k = 0; k < ROW_BITS; k++) begin : g_bit
        localparam int P = ROW_BITS - 1 - k;
        logic prev_b, next_b;
        if (k == 0) begin : g_first
            assign prev_b = 1'b0;
        end else begin : g_inner_l
            assign prev_b = r_stage.this_row[P+1];
        end
        if (k == ROW_BITS - 1) begin : g_last
            assign next_b = 1'b0;
        end else begin : g_inner_r
            assign next_b = r_stage.this_row[P-1];
        end
        ilre_bit_decode u_dec (
            .i_set   (r_stage.this_row[P]),
            .i_prev  (prev_b),
            .i_next  (next_b),
            .i_above (r_stage.above_row[P]),
            .i_below (r_stage.below_row[P]),
            .i_cfg   (shade),
            .o_slots (cell_ld[k+1])
        );
    end

    // Each cell takes its right neighbour's runs when the head cell moves on.
    for (genvar c = 0; c < NC; c++) begin : g_cell
        if (c == NC - 1) begin : g_tail
            assign cell_nx[c] = {SLOTS{RUN_NONE}};
        end else begin : g_body
            assign cell_nx[c] = cell_q[c+1];
        end
        if (c != 0) begin : g_busy
            assign cell_busy[c] = cell_q[c][0].v;
        end
        ilre_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (load),
            .i_load_slots (cell_ld[c]),
            .i_shift      (head_done),
            .i_next_slots (cell_nx[c]),
            .i_pop        ((c == 0) ? cell_q[0][1].v : 1'b0),
            .o_slots      (cell_q[c])
        );
    end

    // The head cell gives out one run per cycle while it holds any. It finishes when it
    // holds no second run, and the line is complete once no cell behind it holds anything.
    assign any_rest  = |cell_busy;
    assign emit      = cell_q[0][0].v;
    assign head_done = !cell_q[0][1].v;
    assign load      = r_stage_v && head_done && !any_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_v <= 1'b0;
        end else if (accept) begin
            r_stage_v <= 1'b1;
        end else if (load) begin
            r_stage_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.pixel_color <= cell_q[0][0].color;
        r_result.run_length  <= cell_q[0][0].len;
        r_result.last_run    <= head_done && !any_rest;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Dropped runs never reach the port.
    a_no_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.run_length != 8'd0))
        else $error("zero-length run delivered");

    // Packing keeps the runs of the head cell at the front.
    a_head_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_q[0][1].v |-> cell_q[0][0].v)
        else $error("head cell has a gap before its second run");

    // A run that is not the last leaves the rest of its line in the chain.
    a_line_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_run) |-> (cell_q[0][0].v || any_rest))
        else $error("line ended without a last run");

    // A staged transaction stays staged until the chain takes it.
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage_v && !load) |=> r_stage_v)
        else $error("staged transaction lost");

endmodule
